/* sv/psm_pkg.sv */
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants of the p-code stack machine execute unit.
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CODE_DEPTH  = 32;
    localparam int MAX_LEVEL   = 3;

    localparam int OP_W   = 4;
    localparam int LEV_W  = 2;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INT = 4'd0,
        OP_STO = 4'd1,
        OP_LIT = 4'd2,
        OP_LOD = 4'd3,
        OP_OPR = 4'd4,
        OP_CAL = 4'd5,
        OP_FCH = 4'd6,
        OP_JMP = 4'd7,
        OP_JPC = 4'd8
    } t_op;

    typedef enum logic [3:0] {
        SUB_NEG = 4'd1,
        SUB_ADD = 4'd2,
        SUB_SUB = 4'd3,
        SUB_MUL = 4'd4,
        SUB_DIV = 4'd5,
        SUB_ODD = 4'd6,
        SUB_EQ  = 4'd7,
        SUB_NE  = 4'd8,
        SUB_LT  = 4'd9,
        SUB_GE  = 4'd10,
        SUB_GT  = 4'd11,
        SUB_LE  = 4'd12
    } t_sub;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_DIV0  = 3'd1,
        ST_OVER  = 3'd2,
        ST_UNDER = 3'd3,
        ST_ADDR  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RDY,
        S_RDX,
        S_WALK,
        S_WALKW,
        S_ADDR,
        S_RDA,
        S_ALU,
        S_DIV,
        S_WR1,
        S_WR2,
        S_WR3,
        S_TOP,
        S_TOPW,
        S_OUT
    } t_state;

endpackage

/* sv/psm_div.sv */
// ----------------------------------------------------------------------------
// psm_div
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module psm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [psm_pkg::DATA_W-1:0]   i_num,
    input  logic signed [psm_pkg::DATA_W-1:0]   i_den,
    output logic                                o_done,
    output logic        [psm_pkg::DATA_W-1:0]   o_quot
);
    localparam int W = psm_pkg::DATA_W;

    logic [W-1:0] r_q, r_d, r_rem;
    logic [5:0]   r_cnt;
    logic         r_busy, r_neg, r_done;
    logic [W:0]   w_trial;
    logic [W-1:0] w_rs;

    assign w_rs    = {r_rem[W-2:0], r_q[W-1]};
    assign w_trial = {1'b0, w_rs} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(W);
                r_neg  <= i_num[W-1] ^ i_den[W-1];
                r_q    <= i_num[W-1] ? W'(-i_num) : i_num;
                r_d    <= i_den[W-1] ? W'(-i_den) : i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_trial[W]) begin
                    r_rem <= w_trial[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rs;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? W'(-r_q) : r_q;
endmodule

/* sv/pcode_stack_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// pcode_stack_machine_execute_unit
// Execute core of a PL/0-style stack machine: one instruction per input item,
// one status item per instruction.
//
//   channel  direction  signals
//   input    in         i_valid, o_stall, i_opcode, i_level, i_operand
//   output   out        o_valid, i_stall, o_next_pc, o_top_value,
//                       o_stack_count, o_halted, o_status
//
// Each item is executed through the single-port stack memory; the unit follows
// one static link per level, and a divide waits on the bit-serial divider.
// After reset the stack memory is cleared, one entry a cycle, while no item
// is accepted. The result is held until taken; the next item is accepted
// only after that.
// ----------------------------------------------------------------------------
module pcode_stack_machine_execute_unit #(
    parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH,
    parameter int CODE_DEPTH  = psm_pkg::CODE_DEPTH,
    parameter int MAX_LEVEL   = psm_pkg::MAX_LEVEL
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [psm_pkg::OP_W-1:0]          i_opcode,
    input  logic [psm_pkg::LEV_W-1:0]         i_level,
    input  logic [psm_pkg::ADDR_W-1:0]        i_operand,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [psm_pkg::ADDR_W-1:0]        o_next_pc,
    output logic signed [psm_pkg::DATA_W-1:0] o_top_value,
    output logic [psm_pkg::CNT_W-1:0]         o_stack_count,
    output logic                              o_halted,
    output logic [psm_pkg::STAT_W-1:0]        o_status
);
    localparam int DW = psm_pkg::DATA_W;
    localparam int AW = psm_pkg::ADDR_W;
    localparam int NW = psm_pkg::CNT_W;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = SW + 2;

    logic [DW-1:0] r_mem [STACK_DEPTH];

    psm_pkg::t_state r_state, n_state;
    logic [SW:0]     r_clr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [SW-1:0]   r_base, n_base;
    logic [AW-1:0]   r_pc, n_pc;
    logic [psm_pkg::OP_W-1:0]  r_op;
    logic [psm_pkg::LEV_W-1:0] r_lev, r_walk, n_walk;
    logic [AW-1:0]   r_opd;
    logic [SW-1:0]   r_frame, n_frame;
    logic [DW-1:0]   r_x, n_x, r_y, n_y, r_top, n_top;
    logic [psm_pkg::STAT_W-1:0] r_stat, n_stat;

    logic            w_we, w_div_go, w_div_done;
    logic [SW-1:0]   w_addr;
    logic [DW-1:0]   w_wdata, r_rdata, w_quot, w_alu;
    logic [CW:0]     w_need;
    logic [SW+AW:0]  w_fa;
    logic [psm_pkg::OP_W-1:0] w_opr_need;
    logic            w_binary, w_known;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    psm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_x),
        .i_den   (r_y),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psm_pkg::S_IDLE;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_base  <= '0;
            r_pc    <= '0;
            r_top   <= '0;
        end else begin
            if (r_clr <= (SW+1)'(STACK_DEPTH - 1)) r_clr <= r_clr + 1'b1;
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_base  <= n_base;
            r_pc    <= n_pc;
            r_top   <= n_top;
        end
        if (o_valid == 1'b0 && r_state == psm_pkg::S_IDLE && i_valid && !o_stall) begin
            r_op  <= i_opcode;
            r_lev <= i_level;
            r_opd <= i_operand;
        end
        r_walk  <= n_walk;
        r_frame <= n_frame;
        r_x     <= n_x;
        r_y     <= n_y;
        r_stat  <= n_stat;
    end

    assign w_binary = (r_opd >= AW'(2)) && (r_opd <= AW'(12)) && (r_opd != AW'(6));
    assign w_known  = (r_opd >= AW'(1)) && (r_opd <= AW'(12));
    assign w_opr_need = w_binary ? 4'd2 : 4'd1;
    assign w_fa     = (SW+AW+1)'(r_frame) + (SW+AW+1)'(r_opd);
    assign w_need   = (CW+1)'(r_cnt);

    always_comb begin
        unique case (r_opd[3:0])
            psm_pkg::SUB_NEG: w_alu = DW'(0) - r_x;
            psm_pkg::SUB_ADD: w_alu = r_x + r_y;
            psm_pkg::SUB_SUB: w_alu = r_x - r_y;
            psm_pkg::SUB_MUL: w_alu = r_x * r_y;
            psm_pkg::SUB_ODD: w_alu = DW'(r_x[0]);
            psm_pkg::SUB_EQ:  w_alu = DW'(r_x == r_y);
            psm_pkg::SUB_NE:  w_alu = DW'(r_x != r_y);
            psm_pkg::SUB_LT:  w_alu = DW'($signed(r_x) <  $signed(r_y));
            psm_pkg::SUB_GE:  w_alu = DW'($signed(r_x) >= $signed(r_y));
            psm_pkg::SUB_GT:  w_alu = DW'($signed(r_x) >  $signed(r_y));
            psm_pkg::SUB_LE:  w_alu = DW'($signed(r_x) <= $signed(r_y));
            default:          w_alu = r_x;
        endcase
    end

    assign o_stall = (r_state != psm_pkg::S_IDLE) || (r_clr <= (SW+1)'(STACK_DEPTH - 1));
    assign o_valid = (r_state == psm_pkg::S_OUT);
    assign o_next_pc     = r_pc;
    assign o_top_value   = (r_cnt == '0) ? '0 : r_top;
    assign o_stack_count = NW'(r_cnt);
    assign o_halted      = (r_pc >= AW'(CODE_DEPTH));
    assign o_status      = r_stat;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_pc     = r_pc;
        n_walk   = r_walk;
        n_frame  = r_frame;
        n_x      = r_x;
        n_y      = r_y;
        n_top    = r_top;
        n_stat   = r_stat;
        w_we     = 1'b0;
        w_addr   = SW'(r_cnt - 1'b1);
        w_wdata  = r_x;
        w_div_go = 1'b0;
        if (r_clr <= (SW+1)'(STACK_DEPTH - 1)) begin
            w_we    = 1'b1;
            w_addr  = r_clr[SW-1:0];
            w_wdata = '0;
        end
        unique case (r_state)
            psm_pkg::S_IDLE: begin
                if (i_valid && !o_stall) n_state = psm_pkg::S_DECODE;
            end
            psm_pkg::S_DECODE: begin
                n_pc    = r_pc + 1'b1;
                n_stat  = psm_pkg::ST_OK;
                n_walk  = r_lev;
                n_frame = r_base;
                n_state = psm_pkg::S_TOP;
                unique case (r_op)
                    psm_pkg::OP_INT: begin
                        if ((CW+AW)'(r_cnt) + (CW+AW)'(r_opd) > (CW+AW)'(STACK_DEPTH))
                            n_stat = psm_pkg::ST_OVER;
                        else
                            n_cnt = CW'((CW+AW)'(r_cnt) + (CW+AW)'(r_opd));
                    end
                    psm_pkg::OP_STO, psm_pkg::OP_JPC: begin
                        if (r_cnt == '0) n_stat = psm_pkg::ST_UNDER;
                        else n_state = psm_pkg::S_RDY;
                    end
                    psm_pkg::OP_LIT: begin
                        if (r_cnt >= CW'(STACK_DEPTH)) n_stat = psm_pkg::ST_OVER;
                        else begin
                            n_x = DW'(r_opd);
                            n_state = psm_pkg::S_WR1;
                        end
                    end
                    psm_pkg::OP_LOD: begin
                        if (r_cnt >= CW'(STACK_DEPTH)) n_stat = psm_pkg::ST_OVER;
                        else n_state = psm_pkg::S_WALK;
                    end
                    psm_pkg::OP_CAL: begin
                        if (w_need + (CW+1)'(3) > (CW+1)'(STACK_DEPTH))
                            n_stat = psm_pkg::ST_OVER;
                        else n_state = psm_pkg::S_WALK;
                    end
                    psm_pkg::OP_OPR: begin
                        if (!w_known) n_state = psm_pkg::S_TOP;
                        else if (r_cnt < CW'(w_opr_need)) n_stat = psm_pkg::ST_UNDER;
                        else n_state = psm_pkg::S_RDY;
                    end
                    psm_pkg::OP_JMP: n_pc = r_opd;
                    default: ;
                endcase
            end
            psm_pkg::S_RDY: begin
                w_addr  = SW'(r_cnt - 1'b1);
                n_state = psm_pkg::S_RDX;
            end
            psm_pkg::S_RDX: begin
                w_addr = SW'(r_cnt - 2'd2);
                if (r_op == psm_pkg::OP_OPR && w_binary) begin
                    n_y = r_rdata;
                    n_state = psm_pkg::S_RDA;
                end else begin
                    n_x = r_rdata;
                    if (r_op == psm_pkg::OP_JPC) begin
                        if (r_rdata == '0) n_pc = r_opd;
                        n_cnt   = r_cnt - 1'b1;
                        n_state = psm_pkg::S_TOP;
                    end else if (r_op == psm_pkg::OP_STO) n_state = psm_pkg::S_WALK;
                    else n_state = psm_pkg::S_ALU;
                end
            end
            psm_pkg::S_WALK: begin
                w_addr = r_frame;
                if (int'(r_lev) > MAX_LEVEL) begin
                    n_stat = psm_pkg::ST_ADDR;
                    n_state = psm_pkg::S_TOP;
                end else if (r_walk == '0) n_state = psm_pkg::S_ADDR;
                else n_state = psm_pkg::S_WALKW;
            end
            psm_pkg::S_WALKW: begin
                if (r_rdata >= DW'(STACK_DEPTH)) begin
                    n_stat = psm_pkg::ST_ADDR;
                    n_state = psm_pkg::S_TOP;
                end else begin
                    n_frame = SW'(r_rdata);
                    n_walk  = r_walk - 1'b1;
                    n_state = psm_pkg::S_WALK;
                end
            end
            psm_pkg::S_ADDR: begin
                w_addr = SW'(w_fa);
                if (r_op == psm_pkg::OP_CAL) begin
                    n_x = DW'(r_frame);
                    n_state = psm_pkg::S_WR1;
                end else if (w_fa >= (SW+AW+1)'(STACK_DEPTH)) begin
                    n_stat = psm_pkg::ST_ADDR;
                    n_state = psm_pkg::S_TOP;
                end else if (r_op == psm_pkg::OP_STO) begin
                    w_we = 1'b1;
                    w_wdata = r_x;
                    n_cnt = r_cnt - 1'b1;
                    n_state = psm_pkg::S_TOP;
                end else n_state = psm_pkg::S_RDA;
            end
            psm_pkg::S_RDA: begin
                if (r_op == psm_pkg::OP_LOD) begin
                    n_x = r_rdata;
                    n_state = psm_pkg::S_WR1;
                end else begin
                    n_x = r_rdata;
                    n_state = psm_pkg::S_ALU;
                end
            end
            psm_pkg::S_ALU: begin
                if (r_opd[3:0] == psm_pkg::SUB_DIV) begin
                    if (r_y == '0) begin
                        n_stat = psm_pkg::ST_DIV0;
                        n_state = psm_pkg::S_TOP;
                    end else begin
                        w_div_go = 1'b1;
                        n_state = psm_pkg::S_DIV;
                    end
                end else begin
                    n_x = w_alu;
                    if (w_binary) n_cnt = r_cnt - 1'b1;
                    n_state = psm_pkg::S_WR1;
                end
            end
            psm_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_x = w_quot;
                    n_cnt = r_cnt - 1'b1;
                    n_state = psm_pkg::S_WR1;
                end
            end
            psm_pkg::S_WR1: begin
                w_we = 1'b1;
                w_wdata = r_x;
                if (r_op == psm_pkg::OP_OPR) begin
                    w_addr = SW'(r_cnt - 1'b1);
                    n_state = psm_pkg::S_TOP;
                end else if (r_op == psm_pkg::OP_CAL) begin
                    w_addr = SW'(r_cnt);
                    n_state = psm_pkg::S_WR2;
                end else begin
                    w_addr = SW'(r_cnt);
                    n_cnt = r_cnt + 1'b1;
                    n_state = psm_pkg::S_TOP;
                end
            end
            psm_pkg::S_WR2: begin
                w_we = 1'b1;
                w_addr = SW'(r_cnt + 1'b1);
                w_wdata = DW'(r_base);
                n_state = psm_pkg::S_WR3;
            end
            psm_pkg::S_WR3: begin
                w_we = 1'b1;
                w_addr = SW'(r_cnt + 2'd2);
                w_wdata = DW'(r_pc);
                n_base = SW'(r_cnt);
                n_pc = r_opd;
                n_state = psm_pkg::S_TOP;
            end
            psm_pkg::S_TOP: begin
                w_addr = SW'(r_cnt - 1'b1);
                n_state = psm_pkg::S_TOPW;
            end
            psm_pkg::S_TOPW: begin
                n_top = r_rdata;
                n_state = psm_pkg::S_OUT;
            end
            psm_pkg::S_OUT: begin
                if (!i_stall) n_state = psm_pkg::S_IDLE;
            end
            default: n_state = psm_pkg::S_IDLE;
        endcase
    end
endmodule
